>>> sv/tpcc_pkg.sv
package tpcc_pkg;

  localparam int KIND_W  = 2;
  localparam int INDEX_W = 10;
  localparam int CODE_W  = 32;
  localparam int KEY_W   = 20;
  localparam int CFG_W   = 11;
  localparam int COUNT_W = 21;

  localparam logic [COUNT_W-1:0] COUNT_TOP = 21'h100000;

  // floor(n / 3) == (n * RECIP3) >> RECIP3_SHIFT for every 32-bit n
  localparam logic [CODE_W-1:0] RECIP3       = 32'hAAAA_AAAB;
  localparam int                RECIP3_SHIFT = 33;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

>>> sv/tpcc_if.sv
interface tpcc_in_if import tpcc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [INDEX_W-1:0]   index;
  logic [CODE_W-1:0]    code;
  logic [KEY_W-1:0]     key;

  modport source (output valid, kind, index, code, key, input ready);
  modport sink   (input valid, kind, index, code, key, output ready);
endinterface

interface tpcc_out_if import tpcc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               matched;
  logic [COUNT_W-1:0] match_count;

  modport source (output valid, matched, match_count, input ready);
  modport sink   (input valid, matched, match_count, output ready);
endinterface

>>> sv/tpcc_decode.sv
module tpcc_decode import tpcc_pkg::*; #(
  parameter int KEY_BITS = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [CODE_W-1:0]   code,
  output logic                done,
  output logic [KEY_BITS-1:0] value,
  output logic [KEY_BITS-1:0] care_free
);

  localparam int CNT_W = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int PROD_W = 2 * CODE_W;

  logic              busy;
  logic              phase;
  logic [CNT_W-1:0]  dig_cnt;
  logic [CODE_W-1:0] rest;
  logic [PROD_W-1:0] prod;
  logic [CODE_W-2:0] quot;
  logic [CODE_W-1:0] triple;
  logic [CODE_W-1:0] remainder;
  logic [1:0]        digit;

  // one base-3 digit per multiply step followed by a remainder step
  assign quot      = prod[RECIP3_SHIFT +: CODE_W-1];
  assign triple    = {quot, 1'b0} + {1'b0, quot};
  assign remainder = rest - triple;
  assign digit     = remainder[1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      phase   <= 1'b0;
      done    <= 1'b0;
      dig_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        phase   <= 1'b0;
        dig_cnt <= '0;
      end else if (busy) begin
        phase <= ~phase;
        if (phase) begin
          dig_cnt <= dig_cnt + 1'b1;
          if (dig_cnt == CNT_W'(KEY_BITS - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rest      <= code;
      value     <= '0;
      care_free <= '0;
    end else if (busy) begin
      if (!phase) begin
        prod <= PROD_W'(rest) * PROD_W'(RECIP3);
      end else begin
        rest      <= {1'b0, quot};
        value     <= (value << 1) | KEY_BITS'(digit == 2'd1);
        care_free <= (care_free << 1) | KEY_BITS'(digit == 2'd0);
      end
    end
  end

endmodule

>>> sv/tpcc_mem.sv
module tpcc_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 40
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= store[raddr];
  end

endmodule

>>> sv/ternary_pattern_cover_counter.sv
// Ternary pattern store with key cover query and saturating hit counter.
//
// Channels: request (sink) carries kind, index, code and key; response (source)
// carries matched and match_count. One response per request item. The user must
// write pattern_count (cfg_wr_en, cfg_wr_data) only while idle; not enforced.
//
// Load: the base-3 code is decoded one digit at a time (a multiply step, then
// a remainder step) by a reciprocal multiplier, then written to the pattern
// memory.
// Query: the pattern memory is read one entry per cycle over the first
// min(pattern_count, MAX_PATTERNS) slots.
// Clear and unused kinds skip to the result state.
// One item is in work at a time; the next request is taken as soon as the
// previous result sits in the output register, even if it is not yet taken.
// A stalled response holds its item; the block then waits with the new
// result until the output register frees up.
// Reset clears the count, pattern_count and the handshakes; pattern memory
// contents are undefined until loaded.
module ternary_pattern_cover_counter import tpcc_pkg::*; #(
  parameter int MAX_PATTERNS = 1024,
  parameter int KEY_BITS     = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  tpcc_in_if.sink          request,
  tpcc_out_if.source       response
);

  localparam int AW  = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int LW  = ((AW + 1) > CFG_W) ? (AW + 1) : CFG_W;
  localparam int IW  = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
  localparam int MDW = 2 * KEY_BITS;

  state_t state, state_next;

  logic [CFG_W-1:0]   pattern_count;
  logic [COUNT_W-1:0] hit_total, hit_total_next;
  logic [KIND_W-1:0]  kind_q;
  logic               ld_ok;
  logic [AW-1:0]      ld_addr;
  logic [KEY_BITS-1:0] key_q;
  logic [LW-1:0]      scan_addr;
  logic [LW-1:0]      limit;
  logic               rd_pend;
  logic               hit;
  logic               out_valid;
  logic               out_matched;
  logic [COUNT_W-1:0] out_count;

  logic               in_ready;
  logic               in_accept;
  logic               dec_start;
  logic               dec_done;
  logic               mem_we;
  logic               res_load;
  logic               scan_issue;
  logic               entry_match;
  logic [IW-1:0]      idx_ext;
  logic [KEY_BITS-1:0] dec_value, dec_cf;
  logic [KEY_BITS-1:0] rd_value, rd_cf;
  logic [MDW-1:0]     rdata;

  assign in_accept = request.valid && in_ready;
  assign idx_ext   = IW'(request.index);
  assign limit     = (LW'(pattern_count) > LW'(MAX_PATTERNS)) ? LW'(MAX_PATTERNS)
                                                             : LW'(pattern_count);
  assign scan_issue  = (state == ST_SCAN) && (scan_addr < limit);
  assign rd_value    = rdata[MDW-1:KEY_BITS];
  assign rd_cf       = rdata[KEY_BITS-1:0];
  assign entry_match = &(~(key_q ^ rd_value) | rd_cf);

  tpcc_decode #(.KEY_BITS(KEY_BITS)) u_decode (
    .clk       (clk),
    .rst       (rst),
    .start     (dec_start),
    .code      (request.code),
    .done      (dec_done),
    .value     (dec_value),
    .care_free (dec_cf)
  );

  tpcc_mem #(.DEPTH(MAX_PATTERNS), .AW(AW), .DW(MDW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ld_addr),
    .wdata ({dec_value, dec_cf}),
    .raddr (scan_addr[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (request.valid) begin
          unique case (request.kind)
            KIND_LOAD:  state_next = ST_LOAD;
            KIND_QUERY: state_next = ST_SCAN;
            default:    state_next = ST_DONE;
          endcase
        end
      end
      ST_LOAD: begin
        if (dec_done) state_next = ST_DONE;
      end
      ST_SCAN: begin
        if (!scan_issue && !rd_pend) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || response.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    dec_start = (state == ST_IDLE) && request.valid && (request.kind == KIND_LOAD);
    mem_we    = (state == ST_LOAD) && dec_done && ld_ok;
    res_load  = (state == ST_DONE) && (!out_valid || response.ready);
  end

  always_comb begin
    hit_total_next = hit_total;
    if (res_load) begin
      if (kind_q == KIND_CLEAR) begin
        hit_total_next = '0;
      end else if ((kind_q == KIND_QUERY) && hit && (hit_total < COUNT_TOP)) begin
        hit_total_next = hit_total + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pattern_count <= '0;
      hit_total     <= '0;
      out_valid     <= 1'b0;
      rd_pend       <= 1'b0;
    end else begin
      state     <= state_next;
      hit_total <= hit_total_next;
      if (cfg_wr_en) pattern_count <= cfg_wr_data;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (response.ready) begin
        out_valid <= 1'b0;
      end
      rd_pend <= in_accept ? 1'b0 : scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_q    <= request.kind;
      ld_addr   <= idx_ext[AW-1:0];
      ld_ok     <= idx_ext < IW'(MAX_PATTERNS);
      key_q     <= KEY_BITS'(request.key);
      scan_addr <= '0;
      hit       <= 1'b0;
    end else begin
      if (scan_issue) scan_addr <= scan_addr + 1'b1;
      if (rd_pend && entry_match) hit <= 1'b1;
    end
    if (res_load) begin
      out_matched <= (kind_q == KIND_QUERY) && hit;
      out_count   <= hit_total_next;
    end
  end

  assign request.ready        = in_ready;
  assign response.valid       = out_valid;
  assign response.matched     = out_matched;
  assign response.match_count = out_count;

endmodule

>>> sv/tpcc_chk.sv
module tpcc_chk import tpcc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               matched,
  input logic [COUNT_W-1:0] match_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(matched) && $stable(match_count))
    else $error("response changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("response valid right after reset");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_hit_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && matched |-> match_count != '0)
    else $error("hit reported with zero count");

  a_count_top: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> match_count <= COUNT_TOP)
    else $error("match count above saturation value");

endmodule

bind ternary_pattern_cover_counter tpcc_chk u_tpcc_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (request.valid),
  .in_ready    (request.ready),
  .out_valid   (response.valid),
  .out_ready   (response.ready),
  .matched     (response.matched),
  .match_count (response.match_count)
);
